FILE: rtl/core/ps2sc_pkg.sv
// Package for the PS/2 set 2 scancode decoder: state layout, scancode constants
// and the unshifted and shifted character tables.
// It depends on nothing else and is imported by the decoder top level and the testbench.
package ps2sc_pkg;

  typedef enum logic [1:0] {
    PH_NONE      = 2'd0,
    PH_BREAK     = 2'd1,
    PH_EXT       = 2'd2,
    PH_EXT_BREAK = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CUR_NONE  = 2'd0,
    CUR_LEFT  = 2'd1,
    CUR_RIGHT = 2'd2,
    CUR_RSVD  = 2'd3
  } cursor_t;

  typedef enum logic [1:0] {
    REG_COLOUR_ONE   = 2'd0,
    REG_COLOUR_TWO   = 2'd1,
    REG_COLOUR_THREE = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    phase_t phase;
    logic   lshift;
    logic   rshift;
    logic   alt;
    logic   caps;
  } kbd_state_t;

  localparam int unsigned STATE_W = $bits(kbd_state_t);

  localparam logic [7:0] CODE_EXTENDED = 8'hE0;
  localparam logic [7:0] CODE_BREAK    = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT   = 8'h12;
  localparam logic [7:0] CODE_RSHIFT   = 8'h59;
  localparam logic [7:0] CODE_LALT     = 8'h11;
  localparam logic [7:0] CODE_SPACE    = 8'h29;
  localparam logic [7:0] CODE_BKSP     = 8'h66;
  localparam logic [7:0] CODE_CAPS     = 8'h58;
  localparam logic [7:0] CODE_KP1      = 8'h69;
  localparam logic [7:0] CODE_KP2      = 8'h72;
  localparam logic [7:0] CODE_KP3      = 8'h7A;
  localparam logic [7:0] CODE_LEFT     = 8'h6B;
  localparam logic [7:0] CODE_RIGHT    = 8'h74;
  localparam logic [7:0] CODE_KEY1     = 8'h16;
  localparam logic [7:0] CODE_KEY2     = 8'h1E;

  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_BKSP  = 8'h08;

  localparam logic [7:0] COLOUR_ONE_RST   = 8'd7;
  localparam logic [7:0] COLOUR_TWO_RST   = 8'd10;
  localparam logic [7:0] COLOUR_THREE_RST = 8'd20;

  function automatic logic [7:0] plain_map(input logic [7:0] code);
    logic [7:0] c;
    unique case (code)
      8'h0D: c = 8'h09;
      8'h0E: c = 8'h60;
      8'h15: c = "q";
      8'h16: c = "1";
      8'h1A: c = "z";
      8'h1B: c = "s";
      8'h1C: c = "a";
      8'h1D: c = "w";
      8'h1E: c = "2";
      8'h21: c = "c";
      8'h22: c = "x";
      8'h23: c = "d";
      8'h24: c = "e";
      8'h25: c = "4";
      8'h26: c = "3";
      8'h2A: c = "v";
      8'h2B: c = "f";
      8'h2C: c = "t";
      8'h2D: c = "r";
      8'h2E: c = "5";
      8'h31: c = "n";
      8'h32: c = "b";
      8'h33: c = "h";
      8'h34: c = "g";
      8'h35: c = "y";
      8'h36: c = "6";
      8'h3A: c = "m";
      8'h3B: c = "j";
      8'h3C: c = "u";
      8'h3D: c = "7";
      8'h3E: c = "8";
      8'h41: c = ",";
      8'h42: c = "k";
      8'h43: c = "i";
      8'h44: c = "o";
      8'h45: c = "0";
      8'h46: c = "9";
      8'h49: c = ".";
      8'h4A: c = "/";
      8'h4B: c = "l";
      8'h4C: c = ";";
      8'h4D: c = "p";
      8'h4E: c = "-";
      8'h52: c = 8'h27;
      8'h54: c = "[";
      8'h55: c = "=";
      8'h5A: c = 8'h0A;
      8'h5B: c = "]";
      8'h5D: c = 8'h5C;
      8'h66: c = 8'h08;
      8'h76: c = 8'h1B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_map(input logic [7:0] code);
    logic [7:0] c;
    unique case (code)
      8'h0E: c = "~";
      8'h15: c = "Q";
      8'h16: c = "!";
      8'h1A: c = "Z";
      8'h1B: c = "S";
      8'h1C: c = "A";
      8'h1D: c = "W";
      8'h1E: c = "@";
      8'h21: c = "C";
      8'h22: c = "X";
      8'h23: c = "D";
      8'h24: c = "E";
      8'h25: c = "$";
      8'h26: c = "#";
      8'h2A: c = "V";
      8'h2B: c = "F";
      8'h2C: c = "T";
      8'h2D: c = "R";
      8'h2E: c = "%";
      8'h31: c = "N";
      8'h32: c = "B";
      8'h33: c = "H";
      8'h34: c = "G";
      8'h35: c = "Y";
      8'h36: c = "^";
      8'h3A: c = "M";
      8'h3B: c = "J";
      8'h3C: c = "U";
      8'h3D: c = "&";
      8'h3E: c = "*";
      8'h41: c = "<";
      8'h42: c = "K";
      8'h43: c = "I";
      8'h44: c = "O";
      8'h45: c = ")";
      8'h46: c = "(";
      8'h49: c = ">";
      8'h4A: c = "?";
      8'h4B: c = "L";
      8'h4C: c = ":";
      8'h4D: c = "P";
      8'h4E: c = "_";
      8'h52: c = 8'h22;
      8'h54: c = "{";
      8'h55: c = "+";
      8'h5A: c = 8'h0A;
      8'h5B: c = "}";
      8'h5D: c = "|";
      8'h66: c = 8'h08;
      8'h76: c = 8'h1B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

FILE: rtl/core/ps2sc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// It has no dependencies; width and depth are set by parameters.
module ps2sc_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/ps2_set2_scancode_to_ascii.sv
// Top level of the PS/2 set 2 scancode decoder, with its APB register port.
// It depends on ps2sc_pkg and instantiates ps2sc_ram for the keyboard state.
//
// The decoder takes one scancode byte per clock while the output is not stalled and
// gives exactly one result beat for each byte, via the stage 1 and output registers.
// The prefix, shift, alt and caps lock state sits in a one-entry state RAM, read when
// a byte is accepted and written back when its result moves to the output register;
// a forwarding register covers a byte accepted as the one before is written back,
// so the read-modify-write loop sustains one byte per cycle. An output register parts
// the two channels, so one byte can be accepted while a result waits to be taken.
// The colour registers lie at byte addresses 0, 4 and 8 and should be written
// while the decoder is idle.
module ps2_set2_scancode_to_ascii #(
  parameter int unsigned TABLE_ENTRIES = 132
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_scan_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_ascii_code,
  output logic [1:0]  out_cursor_move,
  output logic        out_colour_valid,
  output logic [7:0]  out_colour_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ps2sc_pkg::*;

  logic [7:0] colour_one_r;
  logic [7:0] colour_two_r;
  logic [7:0] colour_three_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  logic       s1_v_r;
  logic [7:0] s1_code_r;
  logic       s1_adv;
  logic       in_accept;

  logic             fwd_r;
  kbd_state_t       fwd_data_r;
  logic             ram_written_r;
  logic             rd_valid_r;
  logic [STATE_W-1:0] ram_rdata;

  kbd_state_t st;
  kbd_state_t nst;
  logic       released;
  logic       in_range;
  logic [7:0] lk_raw;
  logic [7:0] lk;
  logic [7:0] ch;
  cursor_t    cur;
  logic       cvalid;
  logic [7:0] cval;

  logic       out_valid_r;
  logic [7:0] out_ascii_r;
  cursor_t    out_cursor_r;
  logic       out_cvalid_r;
  logic [7:0] out_cval_r;

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_one_r   <= COLOUR_ONE_RST;
      colour_two_r   <= COLOUR_TWO_RST;
      colour_three_r <= COLOUR_THREE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COLOUR_ONE:   colour_one_r   <= pwdata[7:0];
        REG_COLOUR_TWO:   colour_two_r   <= pwdata[7:0];
        REG_COLOUR_THREE: colour_three_r <= pwdata[7:0];
        REG_NONE:         ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_COLOUR_ONE:   prdata[7:0] = colour_one_r;
      REG_COLOUR_TWO:   prdata[7:0] = colour_two_r;
      REG_COLOUR_THREE: prdata[7:0] = colour_three_r;
      REG_NONE:         prdata = '0;
    endcase
  end

  // Handshake and pipeline control.
  assign s1_adv    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r        <= 1'b0;
      fwd_r         <= 1'b0;
      ram_written_r <= 1'b0;
      rd_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r     <= 1'b1;
        fwd_r      <= s1_adv;
        rd_valid_r <= ram_written_r;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        ram_written_r <= 1'b1;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code_r <= in_scan_byte;
    end
    if (s1_adv) begin
      fwd_data_r   <= nst;
      out_ascii_r  <= ch;
      out_cursor_r <= cur;
      out_cvalid_r <= cvalid;
      out_cval_r   <= cval;
    end
  end

  ps2sc_ram #(
    .DATA_W (STATE_W),
    .DEPTH  (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (1'b0),
    .wdata (nst),
    .re    (in_accept),
    .raddr (1'b0),
    .rdata (ram_rdata)
  );

  // State as seen by the byte in stage 1.
  always_comb begin
    priority if (fwd_r) begin
      st = fwd_data_r;
    end else if (rd_valid_r) begin
      st = kbd_state_t'(ram_rdata);
    end else begin
      st = '0;
    end
  end

  // Table lookup with shift and caps lock.
  assign in_range = (s1_code_r != 8'h00) && (32'(s1_code_r) < TABLE_ENTRIES);
  assign lk_raw   = (st.lshift || st.rshift) ? shift_map(s1_code_r) : plain_map(s1_code_r);

  always_comb begin
    lk = lk_raw;
    if (st.caps && is_letter(lk_raw)) begin
      lk = lk_raw ^ CASE_BIT;
    end
    if (!in_range) begin
      lk = 8'h00;
    end
  end

  // Byte decode.
  always_comb begin
    nst      = st;
    ch       = 8'h00;
    cur      = CUR_NONE;
    cvalid   = 1'b0;
    cval     = 8'h00;
    released = (st.phase == PH_BREAK);
    priority if (st.phase == PH_EXT) begin
      if (s1_code_r == CODE_BREAK) begin
        nst.phase = PH_EXT_BREAK;
      end else begin
        nst.phase = PH_NONE;
        if (s1_code_r == CODE_LEFT) begin
          cur = CUR_LEFT;
        end else if (s1_code_r == CODE_RIGHT) begin
          cur = CUR_RIGHT;
        end
      end
    end else if (st.phase == PH_EXT_BREAK) begin
      nst.phase = PH_NONE;
    end else if (st.phase == PH_NONE && s1_code_r == CODE_EXTENDED) begin
      nst.phase = PH_EXT;
    end else if (st.phase == PH_NONE && s1_code_r == CODE_BREAK) begin
      nst.phase = PH_BREAK;
    end else begin
      nst.phase = PH_NONE;
      priority if (s1_code_r == CODE_LSHIFT) begin
        nst.lshift = !released;
      end else if (s1_code_r == CODE_RSHIFT) begin
        nst.rshift = !released;
      end else if (s1_code_r == CODE_LALT) begin
        nst.alt = !released;
      end else if (s1_code_r == CODE_SPACE) begin
        ch = released ? 8'h00 : CHAR_SPACE;
      end else if (s1_code_r == CODE_BKSP) begin
        ch = released ? 8'h00 : CHAR_BKSP;
      end else if (s1_code_r == CODE_CAPS) begin
        if (!released) begin
          nst.caps = !st.caps;
        end
      end else if (s1_code_r == CODE_KP1) begin
        cvalid = 1'b1;
        cval   = colour_one_r;
      end else if (s1_code_r == CODE_KP2) begin
        cvalid = 1'b1;
        cval   = colour_two_r;
      end else if (s1_code_r == CODE_KP3) begin
        cvalid = 1'b1;
        cval   = colour_three_r;
      end else if (!released) begin
        if (st.alt && (s1_code_r == CODE_KEY1 || s1_code_r == CODE_KEY2)) begin
          ch = CHAR_ZERO - lk;
        end else begin
          ch = lk;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ascii_code   = out_ascii_r;
  assign out_cursor_move  = out_cursor_r;
  assign out_colour_valid = out_cvalid_r;
  assign out_colour_value = out_cval_r;

`ifndef SYNTH
  a_fwd_after_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && in_accept) |=> fwd_r)
    else $error("back-to-back byte did not take the forwarded state");

  a_no_fwd_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !s1_v_r) |=> !fwd_r)
    else $error("forwarding selected with no earlier byte in flight");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_cursor_r != CUR_NONE) && (out_cvalid_r || out_ascii_r != 8'h00)))
    else $error("cursor event given together with another event");

  a_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_cvalid_r) |-> (out_cval_r == 8'h00))
    else $error("colour value set without a colour event");

  a_cursor_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cursor_r != CUR_RSVD))
    else $error("reserved cursor code given");
`endif

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 set 2 scancode decoder and its APB colour registers.
// It depends on ps2sc_pkg and the ps2_set2_scancode_to_ascii top level, and carries its
// own decoder model, with directed key sequences followed by random typing, in part under back-pressure.
module testbench;
  import ps2sc_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 132;
  localparam int NUM_ROWS = 32;
  localparam int NUM_KEYS = 54;
  localparam int NUM_PHASES = 5;
  localparam int KEYS_PER_PHASE = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] ascii;
    cursor_t    cursor;
    logic       colour_valid;
    logic [7:0] colour_value;
  } key_result_t;

  typedef struct packed {
    logic [7:0]  scan;
    logic        pinned;
    key_result_t want;
  } row_t;

  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{8'h00, 1'b1, '{8'h00, CUR_NONE, 1'b0, 8'h00}},
    '{8'hFF, 1'b1, '{8'h00, CUR_NONE, 1'b0, 8'h00}},
    '{CODE_KP1, 1'b1, '{8'h00, CUR_NONE, 1'b1, COLOUR_ONE_RST}},
    '{CODE_KP2, 1'b1, '{8'h00, CUR_NONE, 1'b1, COLOUR_TWO_RST}},
    '{CODE_KP3, 1'b1, '{8'h00, CUR_NONE, 1'b1, COLOUR_THREE_RST}},
    '{CODE_RSHIFT, 1'b0, '0},
    '{8'h1C, 1'b0, '0},
    '{CODE_CAPS, 1'b0, '0},
    '{8'h1C, 1'b0, '0},
    '{CODE_BREAK, 1'b0, '0},
    '{CODE_RSHIFT, 1'b0, '0},
    '{CODE_LALT, 1'b0, '0},
    '{CODE_KEY1, 1'b0, '0},
    '{CODE_KEY2, 1'b0, '0},
    '{CODE_BREAK, 1'b0, '0},
    '{CODE_LALT, 1'b0, '0},
    '{CODE_SPACE, 1'b0, '0},
    '{CODE_BKSP, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_LEFT, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_RIGHT, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_BREAK, 1'b0, '0},
    '{CODE_LEFT, 1'b0, '0},
    '{CODE_BREAK, 1'b0, '0},
    '{CODE_EXTENDED, 1'b0, '0},
    '{CODE_BREAK, 1'b0, '0},
    '{CODE_KP3, 1'b0, '0},
    '{CODE_CAPS, 1'b0, '0}
  };

  localparam logic [7:0] KEY_CODES [NUM_KEYS] = '{
    8'h0D, 8'h0E, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h21,
    8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
    8'h2E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C,
    8'h3D, 8'h3E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55, 8'h5A, 8'h5B, 8'h5D,
    8'h66, 8'h76, 8'h83, 8'h84
  };

  localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 54, 0, 15, 0};
  localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 54, 15, 0};

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_scan_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_ascii_code;
  logic [1:0]  out_cursor_move;
  logic        out_colour_valid;
  logic [7:0]  out_colour_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  phase_t     kbd_phase = PH_NONE;
  logic       lshift_down = 1'b0;
  logic       rshift_down = 1'b0;
  logic       alt_down = 1'b0;
  logic       caps_on = 1'b0;
  logic [7:0] colour_sel [3] = '{COLOUR_ONE_RST, COLOUR_TWO_RST, COLOUR_THREE_RST};

  key_result_t pending_results [$];
  row_t        pinned_rows [$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          keys_sent = 0;
  int          idle_cycles = 0;
  logic        hold_request = 1'b0;
  logic        failed = 1'b0;

  ps2_set2_scancode_to_ascii #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_scan_byte(in_scan_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ascii_code(out_ascii_code),
    .out_cursor_move(out_cursor_move),
    .out_colour_valid(out_colour_valid),
    .out_colour_value(out_colour_value),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Upper byte is the shifted character, lower byte the plain one.
  function automatic logic [15:0] char_pair(input logic [7:0] code);
    case (code)
      8'h0D: return {8'h00, 8'h09};
      8'h0E: return {"~", 8'h60};
      8'h15: return {"Q", "q"};
      8'h16: return {"!", "1"};
      8'h1A: return {"Z", "z"};
      8'h1B: return {"S", "s"};
      8'h1C: return {"A", "a"};
      8'h1D: return {"W", "w"};
      8'h1E: return {"@", "2"};
      8'h21: return {"C", "c"};
      8'h22: return {"X", "x"};
      8'h23: return {"D", "d"};
      8'h24: return {"E", "e"};
      8'h25: return {"$", "4"};
      8'h26: return {"#", "3"};
      8'h2A: return {"V", "v"};
      8'h2B: return {"F", "f"};
      8'h2C: return {"T", "t"};
      8'h2D: return {"R", "r"};
      8'h2E: return {"%", "5"};
      8'h31: return {"N", "n"};
      8'h32: return {"B", "b"};
      8'h33: return {"H", "h"};
      8'h34: return {"G", "g"};
      8'h35: return {"Y", "y"};
      8'h36: return {"^", "6"};
      8'h3A: return {"M", "m"};
      8'h3B: return {"J", "j"};
      8'h3C: return {"U", "u"};
      8'h3D: return {"&", "7"};
      8'h3E: return {"*", "8"};
      8'h41: return {"<", ","};
      8'h42: return {"K", "k"};
      8'h43: return {"I", "i"};
      8'h44: return {"O", "o"};
      8'h45: return {")", "0"};
      8'h46: return {"(", "9"};
      8'h49: return {">", "."};
      8'h4A: return {"?", "/"};
      8'h4B: return {"L", "l"};
      8'h4C: return {":", ";"};
      8'h4D: return {"P", "p"};
      8'h4E: return {"_", "-"};
      8'h52: return {8'h22, 8'h27};
      8'h54: return {"{", "["};
      8'h55: return {"+", "="};
      8'h5A: return {8'h0A, 8'h0A};
      8'h5B: return {"}", "]"};
      8'h5D: return {"|", 8'h5C};
      8'h66: return {8'h08, 8'h08};
      8'h76: return {8'h1B, 8'h1B};
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [7:0] code);
    logic [15:0] pair;
    logic [7:0]  c;
    if (code == 8'h00 || int'(code) >= int'(TABLE_ENTRIES)) return 8'h00;
    pair = char_pair(code);
    c = (lshift_down || rshift_down) ? pair[15:8] : pair[7:0];
    if (caps_on && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) c = c ^ CASE_BIT;
    return c;
  endfunction

  function automatic key_result_t decode_scan(input logic [7:0] code);
    key_result_t r;
    logic        released;
    r = '0;
    released = 1'b0;
    if (kbd_phase == PH_EXT) begin
      if (code == CODE_BREAK) begin
        kbd_phase = PH_EXT_BREAK;
      end else begin
        if (code == CODE_LEFT) r.cursor = CUR_LEFT;
        else if (code == CODE_RIGHT) r.cursor = CUR_RIGHT;
        kbd_phase = PH_NONE;
      end
    end else if (kbd_phase == PH_EXT_BREAK) begin
      kbd_phase = PH_NONE;
    end else if (kbd_phase == PH_NONE && code == CODE_EXTENDED) begin
      kbd_phase = PH_EXT;
    end else if (kbd_phase == PH_NONE && code == CODE_BREAK) begin
      kbd_phase = PH_BREAK;
    end else begin
      released = (kbd_phase == PH_BREAK);
      kbd_phase = PH_NONE;
      case (code)
        CODE_LSHIFT: lshift_down = !released;
        CODE_RSHIFT: rshift_down = !released;
        CODE_LALT: alt_down = !released;
        CODE_SPACE: if (!released) r.ascii = CHAR_SPACE;
        CODE_BKSP: if (!released) r.ascii = CHAR_BKSP;
        CODE_CAPS: if (!released) caps_on = !caps_on;
        CODE_KP1: begin
          r.colour_valid = 1'b1;
          r.colour_value = colour_sel[REG_COLOUR_ONE];
        end
        CODE_KP2: begin
          r.colour_valid = 1'b1;
          r.colour_value = colour_sel[REG_COLOUR_TWO];
        end
        CODE_KP3: begin
          r.colour_valid = 1'b1;
          r.colour_value = colour_sel[REG_COLOUR_THREE];
        end
        default: begin
          if (!released) begin
            if (alt_down && (code == CODE_KEY1 || code == CODE_KEY2)) begin
              r.ascii = CHAR_ZERO - key_char(code);
            end else begin
              r.ascii = key_char(code);
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic pinned, input key_result_t want);
    row_t row;
    row.scan = b;
    row.pinned = pinned;
    row.want = want;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pinned_rows.push_back(row);
    in_valid <= 1'b1;
    in_scan_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_key(input logic [7:0] b);
    offer_byte(b, 1'b0, '0);
    keys_sent++;
  endtask

  task automatic type_keystroke();
    int         pick;
    logic [7:0] code;
    int         release_pct;
    pick = $urandom_range(99);
    code = KEY_CODES[$urandom_range(NUM_KEYS - 1)];
    release_pct = 25;
    if (pick < 12) begin
      case ($urandom_range(2))
        0: code = CODE_LSHIFT;
        1: code = CODE_RSHIFT;
        default: code = CODE_LALT;
      endcase
      release_pct = 50;
    end else if (pick < 17) begin
      code = CODE_CAPS;
    end else if (pick < 25) begin
      case ($urandom_range(2))
        0: code = CODE_KP1;
        1: code = CODE_KP2;
        default: code = CODE_KP3;
      endcase
    end else if (pick < 33) begin
      send_key(CODE_EXTENDED);
      if ($urandom_range(3) == 0) send_key(CODE_BREAK);
      case ($urandom_range(3))
        0: send_key(CODE_LEFT);
        1: send_key(CODE_RIGHT);
        default: send_key(8'($urandom_range(255)));
      endcase
      return;
    end else if (pick < 43) begin
      send_key(8'($urandom_range(255)));
      return;
    end else if (pick < 47) begin
      send_key($urandom_range(1) ? CODE_BREAK : CODE_EXTENDED);
      send_key($urandom_range(1) ? CODE_BREAK : CODE_EXTENDED);
      return;
    end else if (pick < 52) begin
      code = $urandom_range(1) ? CODE_KEY1 : CODE_KEY2;
    end
    if (int'($urandom_range(99)) < release_pct) send_key(CODE_BREAK);
    send_key(code);
  endtask

  task automatic write_colour(input reg_idx_t idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    colour_sel[idx] = value;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_stall <= (int'($urandom_range(99)) < stall_pct);
    end
  end

  always @(posedge clk) begin : beat_check
    row_t        pin;
    key_result_t predicted;
    key_result_t want;
    logic        moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = decode_scan(in_scan_byte);
        pin = pinned_rows.pop_front();
        pending_results.push_back(pin.pinned ? pin.want : predicted);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result beat arrived with nothing expected");
          failed = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (out_ascii_code !== want.ascii) begin
            $error("ascii_code: expected %02h, got %02h", want.ascii, out_ascii_code);
            failed = 1'b1;
          end
          if (out_cursor_move !== want.cursor) begin
            $error("cursor_move: expected %0d, got %0d", want.cursor, out_cursor_move);
            failed = 1'b1;
          end
          if (out_colour_valid !== want.colour_valid) begin
            $error("colour_valid: expected %0d, got %0d", want.colour_valid, out_colour_valid);
            failed = 1'b1;
          end
          if (out_colour_value !== want.colour_value) begin
            $error("colour_value: expected %02h, got %02h", want.colour_value, out_colour_value);
            failed = 1'b1;
          end
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_byte(DIRECTED[i].scan, DIRECTED[i].pinned, DIRECTED[i].want);
    end
    drain_results();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          c1 = 8'h00;
          c2 = 8'hFF;
          c3 = 8'h00;
        end
        1: begin
          c1 = 8'hFF;
          c2 = 8'h00;
          c3 = 8'hFF;
        end
        default: begin
          c1 = 8'($urandom_range(255));
          c2 = 8'($urandom_range(255));
          c3 = 8'($urandom_range(255));
        end
      endcase
      write_colour(REG_COLOUR_ONE, c1);
      write_colour(REG_COLOUR_TWO, c2);
      write_colour(REG_COLOUR_THREE, c3);
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      if (p == NUM_PHASES - 1) hold_request = 1'b1;
      keys_sent = 0;
      while (keys_sent < KEYS_PER_PHASE) type_keystroke();
      drain_results();
    end
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ps2sc_pkg.sv
rtl/core/ps2sc_ram.sv
rtl/core/ps2_set2_scancode_to_ascii.sv
tb/sv/testbench.sv
